>>> hdl/sfpr_pkg.sv
// ----------------------------------------------------------------------------
// sfpr_pkg
// Shared types and constants of the sync framed packet receiver.
// ----------------------------------------------------------------------------
package sfpr_pkg;

  // Operation codes of an input transfer
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_HEAD    = 2'd0;
  localparam logic [1:0] REG_TAIL    = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TIMER_W    = 16;
  localparam int unsigned OUT_IDX_W  = 6;

  localparam logic [BYTE_W-1:0]  HEAD_RESET    = 8'hAA;
  localparam logic [BYTE_W-1:0]  TAIL_RESET    = 8'h55;
  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd50;

  // Framer requests towards the packet store
  typedef struct packed {
    logic wr;    // store the received byte in the frame under assembly
    logic push;  // frame complete, hand it to the ring
  } frm_evt_t;

endpackage

>>> hdl/sfpr_if.sv
// ----------------------------------------------------------------------------
// sfpr_rx_if / sfpr_pkt_if
// Valid/ready channels for input items and popped packet bytes.
// ----------------------------------------------------------------------------
interface sfpr_rx_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface sfpr_pkt_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic [5:0] byte_index;
  logic       last;

  modport source (output valid, output packet_byte, output byte_index, output last,
                  input ready);
  modport sink   (input valid, input packet_byte, input byte_index, input last,
                  output ready);
endinterface

>>> hdl/sfpr_framer.sv
// ----------------------------------------------------------------------------
// sfpr_framer
// Frame assembly state: fill level and inter-byte countdown.
// ----------------------------------------------------------------------------
module sfpr_framer #(
  parameter int unsigned FRAME_LEN = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          byte_v_i,
  input  logic                          tick_v_i,
  input  logic [sfpr_pkg::BYTE_W-1:0]   rx_byte_i,
  input  logic [sfpr_pkg::BYTE_W-1:0]   head_byte_i,
  input  logic [sfpr_pkg::BYTE_W-1:0]   tail_byte_i,
  input  logic [sfpr_pkg::TIMER_W-1:0]  timeout_i,
  output sfpr_pkg::frm_evt_t            evt_o,
  output logic [$clog2(FRAME_LEN)-1:0]  widx_o
);
  import sfpr_pkg::*;

  localparam int unsigned IW = $clog2(FRAME_LEN);
  localparam int unsigned FW = $clog2(FRAME_LEN + 1);

  logic [FW-1:0]      fill_q, fill_d;
  logic [TIMER_W-1:0] cd_q, cd_d;
  logic               is_head, is_tail, is_mid;

  assign is_head = (fill_q == '0) && (rx_byte_i == head_byte_i);
  assign is_tail = (fill_q == FW'(FRAME_LEN - 1)) && (rx_byte_i == tail_byte_i);
  assign is_mid  = (fill_q != '0) && (fill_q != FW'(FRAME_LEN));

  // every write lands below FRAME_LEN, so the low bits are the position
  assign widx_o = fill_q[IW-1:0];

  always_comb begin
    fill_d     = fill_q;
    cd_d       = cd_q;
    evt_o.wr   = 1'b0;
    evt_o.push = 1'b0;
    if (byte_v_i) begin
      if (is_head) begin
        evt_o.wr = 1'b1;
        fill_d   = FW'(1);
        cd_d     = timeout_i;
      end else if (is_tail) begin
        evt_o.wr   = 1'b1;
        evt_o.push = 1'b1;
        fill_d     = '0;
        cd_d       = '0;
      end else if (is_mid) begin
        evt_o.wr = 1'b1;
        fill_d   = fill_q + FW'(1);
        cd_d     = timeout_i;
      end
    end else if (tick_v_i) begin
      if ((fill_q != '0) && (cd_q <= TIMER_W'(1))) begin
        // drop the partial frame
        fill_d = '0;
        cd_d   = '0;
      end else if (cd_q != '0) begin
        cd_d = cd_q - TIMER_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cd_q   <= '0;
    end else begin
      fill_q <= fill_d;
      cd_q   <= cd_d;
    end
  end

endmodule

>>> hdl/sync_framed_packet_receiver_fifo_unit.sv
// ----------------------------------------------------------------------------
// sync_framed_packet_receiver_fifo_unit
// Fixed-length head/tail framer feeding a ring of packet slots.
// ----------------------------------------------------------------------------
// Usage: rx_i carries items (operation, rx_byte): a received byte, a timer
// tick or a pop. Bytes and ticks give no output.
// A pop on a non-empty ring streams the oldest packet on pkt_o, FRAME_LEN
// transfers, byte_index counting from 0 and last set on the final byte.
// rx_i.ready stays low while the pop sequencer issues its FRAME_LEN reads,
// so a pop holds the input until the last read is issued; the first byte
// passes the pop-active flag, the memory read register and the output
// register in turn. The rate is set by the single read port of the packet
// memory, one byte a cycle while pkt_o does not stall.
// Frames are assembled straight into a spare slot of a memory holding
// SLOT_COUNT+1 slots, so completing a frame only moves the write pointer.
// Reset clears pointers, counts and timers and restores the registers;
// memory contents are not cleared and no clearing pass is needed.
// A stall on pkt_o holds the output register and halts reads until it drains.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i.
// ----------------------------------------------------------------------------
module sync_framed_packet_receiver_fifo_unit #(
  parameter int unsigned FRAME_LEN  = 16,
  parameter int unsigned SLOT_COUNT = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sfpr_rx_if.sink                         rx_i,
  sfpr_pkt_if.source                      pkt_o,
  input  logic                            cfg_we_i,
  input  logic [sfpr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfpr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sfpr_pkg::*;

  localparam int unsigned IW        = $clog2(FRAME_LEN);
  localparam int unsigned PW        = $clog2(SLOT_COUNT + 1);
  localparam int unsigned AW        = PW + IW;
  localparam int unsigned MEM_DEPTH = (SLOT_COUNT + 1) << IW;

  // configuration
  logic [BYTE_W-1:0]  head_q, tail_q;
  logic [TIMER_W-1:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= HEAD_RESET;
      tail_q    <= TAIL_RESET;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HEAD:    head_q    <= cfg_data_i[BYTE_W-1:0];
        REG_TAIL:    tail_q    <= cfg_data_i[BYTE_W-1:0];
        REG_TIMEOUT: timeout_q <= cfg_data_i[TIMER_W-1:0];
        default:     ;
      endcase
    end
  end

  // input transfer decode
  logic     rx_xfer, byte_v, tick_v, pop_req;
  logic     pop_active_q;
  frm_evt_t evt;
  logic [IW-1:0] widx;

  logic [PW-1:0] wp_q, rp_q, count_q;

  assign rx_i.ready = !pop_active_q;
  assign rx_xfer    = rx_i.valid && rx_i.ready;
  assign byte_v     = rx_xfer && (rx_i.operation == OP_BYTE);
  assign tick_v     = rx_xfer && (rx_i.operation == OP_TICK);
  assign pop_req    = rx_xfer && (rx_i.operation == OP_POP) && (count_q != '0);

  sfpr_framer #(
    .FRAME_LEN (FRAME_LEN)
  ) u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_v_i    (byte_v),
    .tick_v_i    (tick_v),
    .rx_byte_i   (rx_i.rx_byte),
    .head_byte_i (head_q),
    .tail_byte_i (tail_q),
    .timeout_i   (timeout_q),
    .evt_o       (evt),
    .widx_o      (widx)
  );

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(SLOT_COUNT)) ? '0 : p + PW'(1);
  endfunction

  // ring pointers; the assembly slot is wp_q, never a stored one
  logic push_ok;
  assign push_ok = byte_v && evt.push && (count_q != PW'(SLOT_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else if (push_ok) begin
      wp_q    <= ptr_inc(wp_q);
      count_q <= count_q + PW'(1);
    end else if (pop_req) begin
      rp_q    <= ptr_inc(rp_q);
      count_q <= count_q - PW'(1);
    end
  end

  // pop sequencer and output pipeline
  logic [PW-1:0] rd_slot_q;
  logic [IW-1:0] rd_idx_q, st_idx_q;
  logic          st_last_q, rd_v_q, out_free, rd_issue, rd_end;
  logic          out_v_q, out_last_q;
  logic [BYTE_W-1:0]    out_byte_q, rdata_q;
  logic [OUT_IDX_W-1:0] out_idx_q;

  assign out_free = !out_v_q || pkt_o.ready;
  assign rd_issue = pop_active_q && (!rd_v_q || out_free);
  assign rd_end   = rd_idx_q == IW'(FRAME_LEN - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_active_q <= 1'b0;
      rd_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      if (pop_req) begin
        pop_active_q <= 1'b1;
      end else if (rd_issue && rd_end) begin
        pop_active_q <= 1'b0;
      end
      if (rd_issue) begin
        rd_v_q <= 1'b1;
      end else if (out_free) begin
        rd_v_q <= 1'b0;
      end
      if (out_free) begin
        out_v_q <= rd_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_req) begin
      rd_slot_q <= rp_q;
      rd_idx_q  <= '0;
    end else if (rd_issue) begin
      rd_idx_q <= rd_idx_q + IW'(1);
    end
    if (rd_issue) begin
      st_idx_q  <= rd_idx_q;
      st_last_q <= rd_end;
    end
    if (rd_v_q && out_free) begin
      out_byte_q <= rdata_q;
      out_idx_q  <= OUT_IDX_W'(st_idx_q);
      out_last_q <= st_last_q;
    end
  end

  // packet memory: one write and one registered read a cycle
  logic [BYTE_W-1:0] pkt_mem [MEM_DEPTH];
  logic              mem_we;
  logic [AW-1:0]     waddr, raddr;

  assign mem_we = byte_v && evt.wr;
  assign waddr  = {wp_q, widx};
  assign raddr  = {rd_slot_q, rd_idx_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pkt_mem[waddr] <= rx_i.rx_byte;
    end
    if (rd_issue) begin
      rdata_q <= pkt_mem[raddr];
    end
  end

  assign pkt_o.valid       = out_v_q;
  assign pkt_o.packet_byte = out_byte_q;
  assign pkt_o.byte_index  = out_idx_q;
  assign pkt_o.last        = out_last_q;

  // checks
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= PW'(SLOT_COUNT))
    else $error("ring count above slot count");

  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_issue |-> !mem_we && (rd_slot_q != wp_q))
    else $error("packet read overlaps frame assembly");

  a_pop_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_req |=> pop_active_q && (rd_idx_q == '0))
    else $error("pop did not start the read sequence");

endmodule

>>> tb/sv/sfpr_tb_pkg.sv
// ----------------------------------------------------------------------------
// sfpr_tb_pkg
// Packet scoreboard for the sync framed packet receiver: tracks the framer
// and the slot ring, and checks popped packet bytes in order.
// ----------------------------------------------------------------------------
package sfpr_tb_pkg;

  timeunit 1ns;
  timeprecision 1ps;

  import sfpr_pkg::*;

  localparam int unsigned FRAME_LEN  = 16;
  localparam int unsigned SLOT_COUNT = 4;

  // Operation code that the block leaves unused
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic [5:0] index;
    logic       last;
  } pkt_beat_t;

  class sfpr_frame_scoreboard;
    logic [7:0]  head_val;
    logic [7:0]  tail_val;
    logic [15:0] timeout_val;

    logic [7:0]  frame_buf [FRAME_LEN];
    int unsigned fill;
    logic [15:0] countdown;
    logic [7:0]  ring [SLOT_COUNT][FRAME_LEN];
    int unsigned wr_slot;
    int unsigned held;

    pkt_beat_t   expected_beats[$];
    int unsigned error_count;

    function new();
      head_val    = HEAD_RESET;
      tail_val    = TAIL_RESET;
      timeout_val = TIMEOUT_RESET;
      fill        = 0;
      countdown   = '0;
      wr_slot     = 0;
      held        = 0;
      error_count = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_HEAD:    head_val = data[7:0];
        REG_TAIL:    tail_val = data[7:0];
        REG_TIMEOUT: timeout_val = data;
        default: ;
      endcase
    endfunction

    // Advance the framer and ring by one accepted input transfer
    function void note_input(logic [1:0] op, logic [7:0] b);
      int unsigned slot;
      pkt_beat_t   beat;
      case (op)
        OP_BYTE: begin
          if (fill == 0 && b == head_val) begin
            frame_buf[0] = b;
            fill         = 1;
            countdown    = timeout_val;
          end else if (fill == FRAME_LEN - 1 && b == tail_val) begin
            countdown = '0;
            frame_buf[FRAME_LEN-1] = b;
            // drop the frame when the ring is full, but close it anyway
            if (held < SLOT_COUNT) begin
              for (int k = 0; k < FRAME_LEN; k++) ring[wr_slot][k] = frame_buf[k];
              wr_slot = (wr_slot + 1) % SLOT_COUNT;
              held++;
            end
            fill = 0;
          end else if (fill > 0 && fill < FRAME_LEN) begin
            countdown       = timeout_val;
            frame_buf[fill] = b;
            fill++;
          end
        end
        OP_TICK: begin
          if (fill != 0 && countdown <= 1) begin
            fill      = 0;
            countdown = '0;
          end else if (countdown != 0) begin
            countdown--;
          end
        end
        OP_POP: begin
          if (held != 0) begin
            slot = (wr_slot + SLOT_COUNT - held) % SLOT_COUNT;
            for (int k = 0; k < FRAME_LEN; k++) begin
              beat.data  = ring[slot][k];
              beat.index = 6'(k);
              beat.last  = (k == FRAME_LEN - 1);
              expected_beats.push_back(beat);
            end
            held--;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_beat(logic [7:0] data, logic [5:0] index, logic last);
      pkt_beat_t exp_beat;
      if (expected_beats.size() == 0) begin
        $error("packet transfer with nothing expected: packet_byte %0h byte_index %0d",
               data, index);
        error_count++;
      end else begin
        exp_beat = expected_beats.pop_front();
        if (data !== exp_beat.data) begin
          $error("packet_byte: expected %0h, actual %0h", exp_beat.data, data);
          error_count++;
        end
        if (index !== exp_beat.index) begin
          $error("byte_index: expected %0d, actual %0d", exp_beat.index, index);
          error_count++;
        end
        if (last !== exp_beat.last) begin
          $error("last: expected %0b, actual %0b", exp_beat.last, last);
          error_count++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction
  endclass

endpackage

>>> tb/sv/sync_framed_packet_receiver_fifo_unit_tb.sv
// ----------------------------------------------------------------------------
// sync_framed_packet_receiver_fifo_unit_tb
// Drives bytes, ticks and pops with bursty input and a stalling packet sink,
// under several head/tail/timeout settings, and checks every popped byte.
// ----------------------------------------------------------------------------
module sync_framed_packet_receiver_fifo_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import sfpr_pkg::*;
  import sfpr_tb_pkg::*;

  localparam int unsigned ITEMS_PER_MIX = 62;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;

  sfpr_rx_if  rx ();
  sfpr_pkt_if pkt ();

  sfpr_frame_scoreboard sb;
  int unsigned          burst_left;
  int unsigned          items_sent;

  sync_framed_packet_receiver_fifo_unit #(
    .FRAME_LEN  (FRAME_LEN),
    .SLOT_COUNT (SLOT_COUNT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx),
    .pkt_o      (pkt),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  // Entered and left at a falling edge; bursts of random length, random gaps
  task automatic send_item(logic [1:0] op, logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      rx.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    rx.valid     <= 1'b1;
    rx.operation <= op;
    rx.rx_byte   <= b;
    do @(posedge clk_i); while (!rx.ready);
    sb.note_input(op, b);
    if (op != OP_SPARE) items_sent++;
    @(negedge clk_i);
  endtask

  // Wait until every popped byte has arrived and the pop sequencer is quiet
  task automatic drain();
    rx.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic configure(logic [7:0] head, logic [7:0] tail, logic [15:0] ticks);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_HEAD;
    cfg_data <= {8'h00, head};
    @(negedge clk_i);
    cfg_idx  <= REG_TAIL;
    cfg_data <= {8'h00, tail};
    @(negedge clk_i);
    cfg_idx  <= REG_TIMEOUT;
    cfg_data <= ticks;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sb.write_reg(REG_HEAD, {8'h00, head});
    sb.write_reg(REG_TAIL, {8'h00, tail});
    sb.write_reg(REG_TIMEOUT, ticks);
  endtask

  // Full frame; ticks may fall between bytes, the final byte may miss the tail
  task automatic send_frame(bit good_tail, int unsigned tick_pct);
    logic [7:0] b;
    send_item(OP_BYTE, sb.head_val);
    for (int k = 1; k < FRAME_LEN; k++) begin
      if ($urandom_range(0, 99) < tick_pct) send_item(OP_TICK, 8'($urandom));
      b = 8'($urandom);
      if (k == FRAME_LEN - 1) begin
        if (good_tail) b = sb.tail_val;
        else if (b == sb.tail_val) b = ~b;
      end
      send_item(OP_BYTE, b);
    end
  endtask

  task automatic run_mix(int unsigned n_items, int unsigned tick_pct);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_frame($urandom_range(0, 99) < 85, tick_pct);
      end else if (pick < 65) begin
        send_item(OP_POP, 8'($urandom));
      end else if (pick < 75) begin
        // partial frame left to expire
        n = $urandom_range(0, FRAME_LEN - 2);
        send_item(OP_BYTE, sb.head_val);
        repeat (n) send_item(OP_BYTE, 8'($urandom));
        n = $urandom_range(1, 4);
        repeat (n) send_item(OP_TICK, 8'($urandom));
      end else if (pick < 85) begin
        send_item(OP_TICK, 8'($urandom));
      end else if (pick < 95) begin
        send_item(OP_BYTE, 8'($urandom));
      end else begin
        send_item(OP_SPARE, 8'($urandom));
      end
    end
  endtask

  // Packet sink: mostly ready, short stalls, and calm stretches with none
  initial begin
    int unsigned hold_n;
    int unsigned calm_n;
    hold_n    = 0;
    calm_n    = 0;
    pkt.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (calm_n != 0) begin
        calm_n--;
        pkt.ready <= 1'b1;
      end else if (hold_n != 0) begin
        hold_n--;
        pkt.ready <= 1'b0;
      end else begin
        pkt.ready <= 1'b1;
        case ($urandom_range(0, 9))
          0:       calm_n = $urandom_range(20, 60);
          1, 2:    hold_n = $urandom_range(1, 6);
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (pkt.valid && pkt.ready) sb.check_beat(pkt.packet_byte, pkt.byte_index, pkt.last);
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    sb           = new();
    burst_left   = 0;
    items_sent   = 0;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_HEAD;
    cfg_data     = '0;
    rx.valid     = 1'b0;
    rx.operation = OP_BYTE;
    rx.rx_byte   = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: empty pop, spare op, stray bytes, then one clean packet
    send_item(OP_POP, 8'h00);
    send_item(OP_SPARE, 8'hFF);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_TICK, 8'h5A);
    send_item(OP_BYTE, HEAD_RESET);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_TICK, 8'hA5);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, HEAD_RESET);   // head inside a frame is plain data
    send_item(OP_BYTE, TAIL_RESET);   // tail before the final position too
    repeat (FRAME_LEN - 6) send_item(OP_BYTE, 8'($urandom));
    send_item(OP_BYTE, TAIL_RESET);
    send_item(OP_POP, 8'hFF);

    // Zero timeout: any tick closes an open frame
    configure(8'h00, 8'hFF, 16'd0);
    run_mix(ITEMS_PER_MIX, 0);
    configure(8'hFF, 8'h00, 16'hFFFF);
    run_mix(ITEMS_PER_MIX, 10);
    configure(8'($urandom), 8'($urandom), 16'($urandom_range(1, 3)));
    run_mix(ITEMS_PER_MIX, 8);
    configure(8'($urandom), 8'($urandom), 16'($urandom_range(4, 20)));
    run_mix(ITEMS_PER_MIX, 15);

    drain();
    repeat (16) @(posedge clk_i);
    if (sb.error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
